>>> rtl/trle_pkg.sv
// Shared types, constants and helper functions of the TGA RLE packetizer.
package trle_pkg;

    localparam int DEF_MAX_PACKET        = 128;
    localparam int DEF_PIXELS_PER_RESULT = 4;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 32;
    localparam int HDR_W      = 8;
    localparam int CNT_W      = 3;
    localparam int LEN_W      = 8;
    localparam int IDX_W      = 7;
    localparam int NUM_LANES  = 4;
    localparam int LANE_W     = 2;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = 2;
    localparam int CMD_CNT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [HDR_W-1:0] RUN_FLAG   = 8'h80;
    localparam logic [PIX_W-1:0] MASK_RGB   = 32'h00FF_FFFF;
    localparam logic [PIX_W-1:0] MASK_RGBA  = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RLE_ENABLE    = 1'b0,
        REG_ALPHA_PRESENT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_EMPTY  = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_RAW    = 2'd3
    } t_mode;

    typedef enum logic {
        K_ONE = 1'b0,
        K_RAW = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_SEND  = 2'd2
    } t_bstate;

    typedef struct packed {
        logic rle_enable;
        logic alpha_present;
    } t_cfg;

    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic              hv;
        logic [HDR_W-1:0]  header;
        logic [PIX_W-1:0]  pixel;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic              bank;
        logic [IDX_W-1:0]  addr;
        logic [PIX_W-1:0]  data;
    } t_mem_wr;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_bank_rel;

    function automatic logic [PIX_W-1:0] pix_mask(input logic alpha_present);
        return alpha_present ? MASK_RGBA : MASK_RGB;
    endfunction

    function automatic logic same_pixel(input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b,
                                        input logic alpha_present);
        return ((a ^ b) & pix_mask(alpha_present)) == '0;
    endfunction

    function automatic t_cmd flush_cmd(input t_mode            mode,
                                       input logic [LEN_W-1:0] run_len,
                                       input logic [PIX_W-1:0] run_pix,
                                       input logic [LEN_W-1:0] raw_len,
                                       input logic [PIX_W-1:0] raw_first,
                                       input logic             bank);
        t_cmd             c;
        logic [LEN_W-1:0] lm1;
        c   = '0;
        lm1 = '0;
        unique case (mode)
            MODE_SINGLE: begin
                c.vld   = 1'b1;
                c.kind  = K_ONE;
                c.hv    = 1'b1;
                c.pixel = run_pix;
            end
            MODE_RUN: begin
                lm1      = run_len - LEN_W'(1);
                c.vld    = 1'b1;
                c.kind   = K_ONE;
                c.hv     = 1'b1;
                c.header = RUN_FLAG | {1'b0, lm1[HDR_W-2:0]};
                c.pixel  = run_pix;
            end
            MODE_RAW: begin
                lm1      = raw_len - LEN_W'(1);
                c.vld    = 1'b1;
                c.kind   = K_RAW;
                c.hv     = 1'b1;
                c.header = {1'b0, lm1[HDR_W-2:0]};
                c.pixel  = raw_first;
                c.len    = raw_len;
                c.bank   = bank;
            end
            MODE_EMPTY: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/trle_in_if.sv
// Pixel input channel: valid/ready handshake with one pixel per transaction.
interface trle_in_if;
    import trle_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            end_of_image;

    modport source (output valid, blue, green, red, alpha, end_of_image, input ready);
    modport sink   (input valid, blue, green, red, alpha, end_of_image, output ready);
endinterface

>>> rtl/trle_out_if.sv
// Packet output channel: valid/ready handshake with one result per transaction.
interface trle_out_if;
    import trle_pkg::*;

    logic             valid;
    logic             ready;
    logic             header_valid;
    logic [HDR_W-1:0] header_byte;
    logic [CNT_W-1:0] pixel_count;
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic [PIX_W-1:0] pixel_c;
    logic [PIX_W-1:0] pixel_d;
    logic             last_of_run;

    modport source (output valid, header_valid, header_byte, pixel_count,
                    pixel_a, pixel_b, pixel_c, pixel_d, last_of_run, input ready);
    modport sink   (input valid, header_valid, header_byte, pixel_count,
                    pixel_a, pixel_b, pixel_c, pixel_d, last_of_run, output ready);
endinterface

>>> rtl/trle_cmd_fifo.sv
// Command queue between the classifier front end and the packet emitter.
module trle_cmd_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  trle_pkg::t_cmd                  i_push0,
    input  trle_pkg::t_cmd                  i_push1,
    input  logic                            i_pop,
    output trle_pkg::t_cmd                  o_head,
    output logic                            o_head_vld,
    output logic [trle_pkg::CMD_CNT_W-1:0]  o_free
);
    import trle_pkg::*;

    t_cmd                 r_entry [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wp;
    logic [CMD_PTR_W-1:0] r_rp;
    logic [CMD_CNT_W-1:0] r_cnt;
    logic [CMD_PTR_W-1:0] n_wp;
    logic [CMD_PTR_W-1:0] n_rp;
    logic [CMD_CNT_W-1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp + CMD_PTR_W'(i_push0.vld) + CMD_PTR_W'(i_push1.vld);
        n_rp  = r_rp + CMD_PTR_W'(i_pop);
        n_cnt = r_cnt + CMD_CNT_W'(i_push0.vld) + CMD_CNT_W'(i_push1.vld)
              - CMD_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0.vld) begin
            r_entry[r_wp] <= i_push0;
        end
        if (i_push1.vld) begin
            r_entry[r_wp + CMD_PTR_W'(1)] <= i_push1;
        end
    end

    assign o_head     = r_entry[r_rp];
    assign o_head_vld = (r_cnt != '0);
    assign o_free     = CMD_CNT_W'(CMD_DEPTH) - r_cnt;
endmodule

>>> rtl/trle_front.sv
// Front end: accepts pixels, tracks the packet in progress and issues packet commands.
module trle_front #(
    parameter int MAX_PACKET = trle_pkg::DEF_MAX_PACKET
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    trle_in_if.sink                        i_pix,
    input  trle_pkg::t_cfg                 i_cfg,
    input  logic [trle_pkg::CMD_CNT_W-1:0] i_free,
    input  trle_pkg::t_bank_rel            i_rel,
    output trle_pkg::t_cmd                 o_cmd0,
    output trle_pkg::t_cmd                 o_cmd1,
    output trle_pkg::t_mem_wr              o_wr
);
    import trle_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET);

    t_mode            r_mode;
    logic [LEN_W-1:0] r_run_len;
    logic [PIX_W-1:0] r_run_pix;
    logic [LEN_W-1:0] r_raw_len;
    logic [PIX_W-1:0] r_raw_first;
    logic [PIX_W-1:0] r_last_pix;
    logic             r_wbank;
    logic [1:0]       r_busy;

    t_mode            n_mode;
    logic [LEN_W-1:0] n_run_len;
    logic [PIX_W-1:0] n_run_pix;
    logic [LEN_W-1:0] n_raw_len;
    logic [PIX_W-1:0] n_raw_first;
    logic [PIX_W-1:0] n_last_pix;
    logic             n_wbank;
    logic [1:0]       n_busy;

    logic [PIX_W-1:0] pix;
    logic             fire;
    logic             hit_max;
    logic             raw_push;
    t_cmd             c0;
    t_cmd             c1;
    t_cmd             fl;
    t_mem_wr          wr;

    assign pix         = {i_pix.alpha, i_pix.red, i_pix.green, i_pix.blue};
    assign i_pix.ready = (i_free >= CMD_CNT_W'(2)) && !r_busy[r_wbank];
    assign fire        = i_pix.valid && i_pix.ready;

    always_comb begin
        n_mode      = r_mode;
        n_run_len   = r_run_len;
        n_run_pix   = r_run_pix;
        n_raw_len   = r_raw_len;
        n_raw_first = r_raw_first;
        n_last_pix  = r_last_pix;
        hit_max     = 1'b0;
        c0          = '0;
        c1          = '0;
        fl          = '0;
        wr          = '0;
        if (fire) begin
            if (!i_cfg.rle_enable) begin
                c0 = flush_cmd(r_mode, r_run_len, r_run_pix, r_raw_len, r_raw_first,
                               r_wbank);
                c1.vld   = 1'b1;
                c1.kind  = K_ONE;
                c1.pixel = pix;
                n_mode    = MODE_EMPTY;
                n_run_len = '0;
                n_raw_len = '0;
            end else begin
                unique case (r_mode)
                    MODE_EMPTY: begin
                        n_run_pix = pix;
                        n_mode    = MODE_SINGLE;
                    end
                    MODE_SINGLE: begin
                        if (same_pixel(pix, r_run_pix, i_cfg.alpha_present)) begin
                            n_mode    = MODE_RUN;
                            n_run_len = LEN_W'(2);
                            hit_max   = (n_run_len >= MAX_LEN);
                        end else begin
                            wr.we       = 1'b1;
                            wr.bank     = r_wbank;
                            wr.addr     = IDX_W'(1);
                            wr.data     = pix;
                            n_raw_first = r_run_pix;
                            n_last_pix  = pix;
                            n_raw_len   = LEN_W'(2);
                            n_mode      = MODE_RAW;
                            hit_max     = (n_raw_len >= MAX_LEN);
                        end
                    end
                    MODE_RUN: begin
                        if (same_pixel(pix, r_run_pix, i_cfg.alpha_present)) begin
                            n_run_len = r_run_len + LEN_W'(1);
                            hit_max   = (n_run_len >= MAX_LEN);
                        end else begin
                            c0 = flush_cmd(r_mode, r_run_len, r_run_pix, r_raw_len,
                                           r_raw_first, r_wbank);
                            n_run_pix = pix;
                            n_run_len = '0;
                            n_mode    = MODE_SINGLE;
                        end
                    end
                    MODE_RAW: begin
                        if (same_pixel(pix, r_last_pix, i_cfg.alpha_present)) begin
                            c0 = flush_cmd(r_mode, r_run_len, r_run_pix, r_raw_len,
                                           r_raw_first, r_wbank);
                            n_run_pix = pix;
                            n_raw_len = '0;
                            n_mode    = MODE_SINGLE;
                        end else begin
                            wr.we      = 1'b1;
                            wr.bank    = r_wbank;
                            wr.addr    = r_raw_len[IDX_W-1:0];
                            wr.data    = pix;
                            n_last_pix = pix;
                            n_raw_len  = r_raw_len + LEN_W'(1);
                            hit_max    = (n_raw_len >= MAX_LEN);
                        end
                    end
                endcase
                if (hit_max) begin
                    c0 = flush_cmd(n_mode, n_run_len, n_run_pix, n_raw_len, n_raw_first,
                                   r_wbank);
                    n_mode    = MODE_EMPTY;
                    n_run_len = '0;
                    n_raw_len = '0;
                end
                if (i_pix.end_of_image) begin
                    fl = flush_cmd(n_mode, n_run_len, n_run_pix, n_raw_len, n_raw_first,
                                   r_wbank);
                    if (c0.vld) begin
                        c1 = fl;
                    end else begin
                        c0 = fl;
                    end
                    n_mode    = MODE_EMPTY;
                    n_run_len = '0;
                    n_raw_len = '0;
                end
            end
            if (!c0.vld) begin
                c0 = c1;
                c1 = '0;
            end
            if (c1.vld) begin
                c1.last = 1'b1;
            end else if (c0.vld) begin
                c0.last = 1'b1;
            end
        end
    end

    always_comb begin
        raw_push = (c0.vld && (c0.kind == K_RAW)) || (c1.vld && (c1.kind == K_RAW));
        n_wbank  = raw_push ? ~r_wbank : r_wbank;
        n_busy   = r_busy;
        if (i_rel.vld) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (raw_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_EMPTY;
            r_run_len <= '0;
            r_raw_len <= '0;
            r_wbank   <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_run_len <= n_run_len;
            r_raw_len <= n_raw_len;
            r_wbank   <= n_wbank;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_pix   <= n_run_pix;
        r_raw_first <= n_raw_first;
        r_last_pix  <= n_last_pix;
    end

    assign o_cmd0 = c0;
    assign o_cmd1 = c1;
    assign o_wr   = wr;
endmodule

>>> rtl/trle_back.sv
// Back end: holds the raw pixel store and turns packet commands into output results.
module trle_back #(
    parameter int MAX_PACKET        = trle_pkg::DEF_MAX_PACKET,
    parameter int PIXELS_PER_RESULT = trle_pkg::DEF_PIXELS_PER_RESULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trle_pkg::t_cfg      i_cfg,
    input  trle_pkg::t_cmd      i_head,
    input  logic                i_head_vld,
    output logic                o_pop,
    input  trle_pkg::t_mem_wr   i_wr,
    output trle_pkg::t_bank_rel o_rel,
    trle_out_if.source          o_pkt
);
    import trle_pkg::*;

    localparam int               LANES_USED = (PIXELS_PER_RESULT < 1) ? 1 :
                                              ((PIXELS_PER_RESULT > NUM_LANES) ? NUM_LANES :
                                               PIXELS_PER_RESULT);
    localparam int               AW        = $clog2(MAX_PACKET);
    localparam int               MEM_DEPTH = 2 ** (AW + 1);
    localparam logic [LEN_W-1:0] PPR_LEN   = LEN_W'(LANES_USED);
    localparam logic [CNT_W-1:0] PPR_CNT   = CNT_W'(LANES_USED);

    logic [PIX_W-1:0]  r_mem [MEM_DEPTH];

    t_bstate           r_state;
    t_bstate           n_state;
    logic [LEN_W-1:0]  r_pos;
    logic [LANE_W-1:0] r_lane;
    logic [CNT_W-1:0]  r_res_cnt;
    logic              r_first;
    logic              r_rd_vld;
    logic [LANE_W-1:0] r_rd_lane;
    logic              r_rd_first;
    logic [PIX_W-1:0]  r_rd_data;
    logic [PIX_W-1:0]  r_buf [NUM_LANES];

    logic              r_out_valid;
    logic              r_hv;
    logic [HDR_W-1:0]  r_hdr;
    logic [CNT_W-1:0]  r_cnt;
    logic [PIX_W-1:0]  r_px [NUM_LANES];
    logic              r_last;

    logic              slot_free;
    logic              issue;
    logic              start_raw;
    logic              load_one;
    logic              load_raw;
    logic              done_raw;
    logic              lane_end;
    logic [AW:0]       raddr;
    logic [PIX_W-1:0]  rd_px;
    logic [PIX_W-1:0]  mask;
    logic [LEN_W-1:0]  remaining;
    logic [PIX_W-1:0]  lane_px [NUM_LANES];

    function automatic logic [CNT_W-1:0] chunk(input logic [LEN_W-1:0] rem);
        return (rem > PPR_LEN) ? PPR_CNT : rem[CNT_W-1:0];
    endfunction

    assign slot_free = !r_out_valid || o_pkt.ready;
    assign rd_px     = r_rd_first ? i_head.pixel : r_rd_data;
    assign mask      = pix_mask(i_cfg.alpha_present);
    assign remaining = i_head.len - r_pos;
    assign lane_end  = (r_lane == LANE_W'(r_res_cnt - CNT_W'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head_vld && (i_head.kind == K_RAW)) begin
                    n_state = B_FETCH;
                end
            end
            B_FETCH: begin
                if (lane_end) begin
                    n_state = B_SEND;
                end
            end
            B_SEND: begin
                if (slot_free) begin
                    n_state = (r_pos == i_head.len) ? B_IDLE : B_FETCH;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        issue     = (r_state == B_FETCH);
        start_raw = (r_state == B_IDLE) && i_head_vld && (i_head.kind == K_RAW);
        load_one  = (r_state == B_IDLE) && i_head_vld && (i_head.kind == K_ONE) && slot_free;
        load_raw  = (r_state == B_SEND) && slot_free;
        done_raw  = load_raw && (r_pos == i_head.len);
        o_pop     = load_one || done_raw;
        o_rel.vld  = done_raw;
        o_rel.bank = i_head.bank;
        raddr     = {i_head.bank, r_pos[AW-1:0]};
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_px[i] = (r_rd_vld && (r_rd_lane == LANE_W'(i))) ? rd_px : r_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{i_wr.bank, i_wr.addr[AW-1:0]}] <= i_wr.data;
        end
        r_rd_data <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_lane      <= '0;
            r_res_cnt   <= '0;
            r_first     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (start_raw) begin
                r_pos     <= '0;
                r_lane    <= '0;
                r_first   <= 1'b1;
                r_res_cnt <= chunk(i_head.len);
            end else if (issue) begin
                r_pos  <= r_pos + LEN_W'(1);
                r_lane <= r_lane + LANE_W'(1);
            end else if (load_raw) begin
                r_first   <= 1'b0;
                r_lane    <= '0;
                r_res_cnt <= chunk(remaining);
            end
            if (load_one || load_raw) begin
                r_out_valid <= 1'b1;
            end else if (o_pkt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_lane  <= r_lane;
        r_rd_first <= (r_pos == '0);
        if (r_rd_vld) begin
            r_buf[r_rd_lane] <= rd_px;
        end
        if (load_one) begin
            r_hv   <= i_head.hv;
            r_hdr  <= i_head.header;
            r_cnt  <= CNT_W'(1);
            r_last <= i_head.last;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_px[i] <= (i == 0) ? (i_head.pixel & mask) : '0;
            end
        end else if (load_raw) begin
            r_hv   <= r_first;
            r_hdr  <= r_first ? i_head.header : '0;
            r_cnt  <= r_res_cnt;
            r_last <= i_head.last && (r_pos == i_head.len);
            for (int i = 0; i < NUM_LANES; i++) begin
                r_px[i] <= (CNT_W'(i) < r_res_cnt) ? (lane_px[i] & mask) : '0;
            end
        end
    end

    assign o_pkt.valid        = r_out_valid;
    assign o_pkt.header_valid = r_hv;
    assign o_pkt.header_byte  = r_hdr;
    assign o_pkt.pixel_count  = r_cnt;
    assign o_pkt.pixel_a      = r_px[0];
    assign o_pkt.pixel_b      = r_px[1];
    assign o_pkt.pixel_c      = r_px[2];
    assign o_pkt.pixel_d      = r_px[3];
    assign o_pkt.last_of_run  = r_last;
endmodule

>>> rtl/tga_rle_pixel_packetizer.sv
// Top level of the TGA run-length pixel packetizer.
// Accepts one pixel per cycle; stalls while the command queue has fewer than two free slots.
// Single-pixel and run results pass through the command queue and then the output register.
// Raw packets are read one stored pixel per cycle while fetching; each result then waits for a free output slot.
// Input also stalls while the raw store bank being filled is still being read out.
// Reset: rle_enable 1, alpha_present 0, packet state empty; the raw store is not cleared.
module tga_rle_pixel_packetizer #(
    parameter int MAX_PACKET        = trle_pkg::DEF_MAX_PACKET,
    parameter int PIXELS_PER_RESULT = trle_pkg::DEF_PIXELS_PER_RESULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    trle_in_if.sink                         i_pix,
    trle_out_if.source                      o_pkt
);
    import trle_pkg::*;

    logic                 r_rle_enable;
    logic                 r_alpha_present;
    t_cfg                 cfg;
    t_cmd                 cmd0;
    t_cmd                 cmd1;
    t_cmd                 head;
    logic                 head_vld;
    logic                 pop;
    logic [CMD_CNT_W-1:0] free;
    t_mem_wr              wr;
    t_bank_rel            rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_enable    <= 1'b1;
            r_alpha_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RLE_ENABLE:    r_rle_enable    <= i_cfg_data[0];
                REG_ALPHA_PRESENT: r_alpha_present <= i_cfg_data[0];
            endcase
        end
    end

    assign cfg.rle_enable    = r_rle_enable;
    assign cfg.alpha_present = r_alpha_present;

    trle_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (cfg),
        .i_free  (free),
        .i_rel   (rel),
        .o_cmd0  (cmd0),
        .o_cmd1  (cmd1),
        .o_wr    (wr)
    );

    trle_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push0    (cmd0),
        .i_push1    (cmd1),
        .i_pop      (pop),
        .o_head     (head),
        .o_head_vld (head_vld),
        .o_free     (free)
    );

    trle_back #(
        .MAX_PACKET        (MAX_PACKET),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .i_wr       (wr),
        .o_rel      (rel),
        .o_pkt      (o_pkt)
    );
endmodule

>>> tb/sv/tga_rle_pixel_packetizer_checker.sv
// Checker for the TGA RLE pixel packetizer: predicts packet words from pixels and compares them.
module tga_rle_pixel_packetizer_checker
    import trle_pkg::*;
#(
    parameter int MAX_PACKET        = DEF_MAX_PACKET,
    parameter int PIXELS_PER_RESULT = DEF_PIXELS_PER_RESULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    trle_in_if                    i_pix,
    trle_out_if                   i_pkt,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1 << IDX_W;
    localparam int PKT_LIMIT   = (MAX_PACKET < 2) ? 2 :
                                 ((MAX_PACKET > STORE_DEPTH) ? STORE_DEPTH : MAX_PACKET);
    localparam int LANES_USED  = (PIXELS_PER_RESULT < 1) ? 1 :
                                 ((PIXELS_PER_RESULT > NUM_LANES) ? NUM_LANES : PIXELS_PER_RESULT);
    localparam logic [HDR_W-1:0] COUNT_MASK = ~RUN_FLAG;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                              hv;
        logic [HDR_W-1:0]                  hdr;
        logic [CNT_W-1:0]                  cnt;
        logic [NUM_LANES-1:0][PIX_W-1:0]   px;
        logic                              last;
    } t_packet_word;

    t_cfg             cfg;
    t_mode            pkt_mode;
    logic [LEN_W-1:0] run_len;
    logic [LEN_W-1:0] raw_len;
    logic [PIX_W-1:0] run_pix;
    logic [PIX_W-1:0] raw_store [STORE_DEPTH];
    t_packet_word     packet_words [$];
    t_packet_word     want;
    int               err_count = 0;
    int               n_results = 0;

    assign o_errors  = err_count;
    assign o_results = n_results;

    function automatic logic [PIX_W-1:0] visible(input logic [PIX_W-1:0] p);
        return p & (cfg.alpha_present ? MASK_RGBA : MASK_RGB);
    endfunction

    task automatic report(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t, result %0d: %s", $time, n_results, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                               input logic [PIX_W-1:0] exp_val);
        if (got !== exp_val) begin
            report($sformatf("%s is %0h, expected %0h", name, got, exp_val));
        end
    endtask

    task automatic split_packet(input logic [HDR_W-1:0] hdr, input logic from_store,
                                input int count);
        t_packet_word w;
        int           done;
        int           n;
        int           j;
        done = 0;
        while (done < count) begin
            n = (count - done > LANES_USED) ? LANES_USED : count - done;
            w = '0;
            w.hv  = (done == 0);
            w.hdr = (done == 0) ? hdr : '0;
            w.cnt = CNT_W'(n);
            for (j = 0; j < n; j++) begin
                w.px[j] = visible(from_store ? raw_store[IDX_W'(done + j)] : run_pix);
            end
            packet_words.push_back(w);
            done += n;
        end
    endtask

    task automatic close_packet();
        case (pkt_mode)
            MODE_SINGLE: split_packet('0, 1'b0, 1);
            MODE_RUN:    split_packet(RUN_FLAG | ((run_len - 1'b1) & COUNT_MASK), 1'b0, 1);
            MODE_RAW: begin
                if (raw_len != 0) begin
                    split_packet((raw_len - 1'b1) & COUNT_MASK, 1'b1, int'(raw_len));
                end
            end
            default: ;
        endcase
        pkt_mode = MODE_EMPTY;
        run_len  = '0;
        raw_len  = '0;
    endtask

    task automatic packetize_pixel(input logic [PIX_W-1:0] p, input logic eoi);
        t_packet_word w;
        int           start_size;
        start_size = packet_words.size();
        if (!cfg.rle_enable) begin
            close_packet();
            w       = '0;
            w.cnt   = CNT_W'(1);
            w.px[0] = visible(p);
            packet_words.push_back(w);
        end else begin
            case (pkt_mode)
                MODE_SINGLE: begin
                    if (visible(p ^ run_pix) == '0) begin
                        pkt_mode = MODE_RUN;
                        run_len  = LEN_W'(2);
                        if (run_len >= PKT_LIMIT) close_packet();
                    end else begin
                        raw_store[0] = run_pix;
                        raw_store[1] = p;
                        raw_len      = LEN_W'(2);
                        pkt_mode     = MODE_RAW;
                        if (raw_len >= PKT_LIMIT) close_packet();
                    end
                end
                MODE_RUN: begin
                    if (visible(p ^ run_pix) == '0) begin
                        run_len++;
                        if (run_len >= PKT_LIMIT) close_packet();
                    end else begin
                        close_packet();
                        run_pix  = p;
                        pkt_mode = MODE_SINGLE;
                    end
                end
                MODE_RAW: begin
                    if (visible(p ^ raw_store[IDX_W'(raw_len - 1'b1)]) == '0) begin
                        close_packet();
                        run_pix  = p;
                        pkt_mode = MODE_SINGLE;
                    end else begin
                        raw_store[IDX_W'(raw_len)] = p;
                        raw_len++;
                        if (raw_len >= PKT_LIMIT) close_packet();
                    end
                end
                default: begin
                    run_pix  = p;
                    pkt_mode = MODE_SINGLE;
                end
            endcase
            if (eoi) close_packet();
        end
        if (packet_words.size() > start_size) begin
            w      = packet_words.pop_back();
            w.last = 1'b1;
            packet_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.rle_enable    = 1'b1;
            cfg.alpha_present = 1'b0;
            pkt_mode          = MODE_EMPTY;
            run_len           = '0;
            raw_len           = '0;
            run_pix           = '0;
            packet_words.delete();
        end else begin
            if (i_pkt.valid && i_pkt.ready) begin
                if (packet_words.size() == 0) begin
                    report("result transaction with no packet word predicted");
                end else begin
                    want = packet_words.pop_front();
                    check_field("header_valid", PIX_W'(i_pkt.header_valid), PIX_W'(want.hv));
                    check_field("header_byte", PIX_W'(i_pkt.header_byte), PIX_W'(want.hdr));
                    check_field("pixel_count", PIX_W'(i_pkt.pixel_count), PIX_W'(want.cnt));
                    check_field("pixel_a", i_pkt.pixel_a, want.px[0]);
                    check_field("pixel_b", i_pkt.pixel_b, want.px[1]);
                    check_field("pixel_c", i_pkt.pixel_c, want.px[2]);
                    check_field("pixel_d", i_pkt.pixel_d, want.px[3]);
                    check_field("last_of_run", PIX_W'(i_pkt.last_of_run), PIX_W'(want.last));
                end
                n_results++;
            end
            if (i_pix.valid && i_pix.ready) begin
                packetize_pixel({i_pix.alpha, i_pix.red, i_pix.green, i_pix.blue},
                                i_pix.end_of_image);
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_RLE_ENABLE:    cfg.rle_enable    = i_cfg_data[0];
                    REG_ALPHA_PRESENT: cfg.alpha_present = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending <= packet_words.size();
    end

endmodule

>>> tb/sv/tga_rle_pixel_packetizer_tb.sv
// Top of the TGA RLE pixel packetizer testbench: clock, reset, pixel stimulus and verdict.
module tga_rle_pixel_packetizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trle_pkg::*;

    localparam int MAX_PACKET        = DEF_MAX_PACKET;
    localparam int PIXELS_PER_RESULT = DEF_PIXELS_PER_RESULT;
    localparam int SETTLE_CYCLES     = 20;
    localparam int HOLD_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT    = 5000;

    typedef enum int {
        SEG_RUN   = 0,
        SEG_RAW   = 1,
        SEG_NOISE = 2
    } t_segment;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_reg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int n_errors;
    int n_pending;
    int n_results;

    int   n_pixels     = 0;
    int   n_settings   = 0;
    int   hold_reqs    = 0;
    int   holds_served = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    logic sink_calm    = 1'b0;
    logic src_calm     = 1'b0;
    logic alpha_cmp    = 1'b0;

    logic [PIX_W-1:0] last_px = '0;
    logic [PIX_W-1:0] palette [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                      32'h00FF_FFFF, 32'hFF00_0000};

    trle_in_if  pix_if ();
    trle_out_if pkt_if ();

    tga_rle_pixel_packetizer #(
        .MAX_PACKET        (MAX_PACKET),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_pkt      (pkt_if)
    );

    tga_rle_pixel_packetizer_checker #(
        .MAX_PACKET        (MAX_PACKET),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .i_pkt      (pkt_if),
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_results  (n_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (holds_served != hold_reqs) begin
            holds_served = hold_reqs;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            pkt_if.ready <= 1'b0;
        end else if (sink_calm || $urandom_range(0, 99) < 65) begin
            pkt_if.ready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                         $urandom_range(0, 2);
            pkt_if.ready <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (pkt_if.valid && pkt_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic eoi);
        int gap;
        int r;
        gap = 0;
        if (!src_calm) begin
            r = $urandom_range(0, 99);
            if (r >= 93) begin
                gap = $urandom_range(8, 40);
            end else if (r >= 65) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        {pix_if.alpha, pix_if.red, pix_if.green, pix_if.blue} <= px;
        pix_if.end_of_image <= eoi;
        do @(posedge clk); while (pix_if.ready !== 1'b1);
        n_pixels++;
    endtask

    task automatic drain();
        pix_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic rle, input logic alpha);
        write_reg(REG_RLE_ENABLE, rle);
        write_reg(REG_ALPHA_PRESENT, alpha);
        alpha_cmp = alpha;
        n_settings++;
    endtask

    task automatic send_segment(input t_segment kind, input int len);
        int               k;
        logic [PIX_W-1:0] px;
        logic             eoi;
        for (k = 0; k < len; k++) begin
            case (kind)
                SEG_RUN: begin
                    px = (k == 0 && $urandom_range(0, 1) == 0) ? PIX_W'($urandom) : last_px;
                    if (!alpha_cmp) px[PIX_W-1 -: CH_W] = CH_W'($urandom);
                end
                SEG_RAW: begin
                    px = $urandom;
                    if (((px ^ last_px) & (alpha_cmp ? MASK_RGBA : MASK_RGB)) == '0) begin
                        px[0] = ~px[0];
                    end
                end
                default: px = palette[$urandom_range(0, 3)];
            endcase
            if (k == len - 1) begin
                eoi = ($urandom_range(0, 3) == 0);
            end else begin
                eoi = (kind == SEG_NOISE) && ($urandom_range(0, 7) == 0);
            end
            send_pixel(px, eoi);
            last_px = px;
        end
    endtask

    task automatic send_stream(input int budget);
        int       sent;
        int       len;
        t_segment kind;
        sent = 0;
        while (sent < budget) begin
            kind = t_segment'($urandom_range(0, 2));
            len  = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 132) :
                                                   $urandom_range(1, 10);
            send_segment(kind, len);
            sent += len;
        end
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= REG_RLE_ENABLE;
        cfg_data            <= '0;
        pix_if.valid        <= 1'b0;
        pix_if.blue         <= '0;
        pix_if.green        <= '0;
        pix_if.red          <= '0;
        pix_if.alpha        <= '0;
        pix_if.end_of_image <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(1'b1, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h1122_3344, 1'b0);
        send_pixel(32'hAA22_3344, 1'b0);
        send_pixel(32'h5566_7788, 1'b1);
        send_pixel(32'h00FF_FFFF, 1'b0);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'h8080_8080, 1'b0);
        send_pixel(32'h8080_8080, 1'b0);
        send_pixel(32'h7F7F_7F7F, 1'b1);
        send_pixel(32'h0101_0101, 1'b0);
        send_pixel(32'h0202_0202, 1'b0);
        send_pixel(32'h0303_0303, 1'b0);
        send_pixel(32'h0404_0404, 1'b0);
        send_pixel(32'h0505_0505, 1'b1);
        send_pixel(32'hAB00_0001, 1'b0);
        drain();
        set_mode(1'b1, 1'b1);
        send_pixel(32'hCD00_0001, 1'b0);
        send_pixel(32'hCD00_0001, 1'b1);
        send_pixel(32'h1234_5678, 1'b0);
        drain();
        set_mode(1'b0, 1'b0);
        send_pixel(32'h9ABC_DEF0, 1'b1);
        last_px = 32'h9ABC_DEF0;

        drain();
        set_mode(1'b1, 1'b0);
        sink_calm <= 1'b1;
        src_calm = 1'b1;
        send_segment(SEG_RUN, 130);
        src_calm = 1'b0;
        sink_calm <= 1'b0;
        send_stream(5);

        drain();
        set_mode(1'b1, 1'b1);
        send_segment(SEG_RAW, 130);
        send_stream(5);

        drain();
        set_mode(1'b0, 1'b0);
        hold_reqs <= hold_reqs + 1;
        send_stream(15);

        drain();
        set_mode(1'b0, 1'b1);
        send_stream(5);

        drain();
        set_mode(1'b1, 1'b0);
        send_stream(5);
        send_pixel($urandom, 1'b1);
        drain();

        $display("covered %0d pixels under %0d register settings, %0d packet results checked",
                 n_pixels, n_settings, n_results);
        $display("runs and raw packets up to the size limit, pass-through and a long output stall");
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/trle_pkg.sv
rtl/trle_in_if.sv
rtl/trle_out_if.sv
rtl/trle_cmd_fifo.sv
rtl/trle_front.sv
rtl/trle_back.sv
rtl/tga_rle_pixel_packetizer.sv
tb/sv/tga_rle_pixel_packetizer_checker.sv
tb/sv/tga_rle_pixel_packetizer_tb.sv
